// ----- src/maa_pkg.sv -----
package maa_pkg;

   // Sizing of the element store and the dimension limit
   localparam int MAX_DIMS    = 4;
   localparam int STORE_DEPTH = 1024;

   // Fixed field widths
   localparam int FIELD_COUNT = 4;
   localparam int COORD_W     = 10;
   localparam int SIZE_W      = 11;
   localparam int DATA_W      = 32;
   localparam int DCNT_W      = 3;
   localparam int CSR_IDX_W   = 3;
   localparam int DSEL_W      = 2;

   // Dimensions that can actually be used
   localparam int DIM_LIM = (MAX_DIMS < FIELD_COUNT) ? MAX_DIMS : FIELD_COUNT;

   // Store address and Horner product widths
   localparam int IDX_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int PROD_W = IDX_W + SIZE_W + 1;

   // Opcodes
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_0    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_1    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_2    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_3    = 3'd4;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [SIZE_W-1:0]  size_type;
   typedef logic [DSEL_W-1:0]  dsel_type;

   // Controller to datapath
   typedef struct packed {
      logic     load;       // latch request beat, clear accumulator
      logic     step;       // one Horner multiply-add
      dsel_type dim_sel;    // dimension worked on by step
      logic     mem_go;     // store access
      logic     clear_go;   // clear one store entry
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      dsel_type last_dim;   // index of the innermost dimension in use
      logic     clear_last; // clear pointer at final entry
   } status_type;

endpackage

// ----- src/multidim_array_access_unit.sv -----
// Multidimensional array access unit. A store of STORE_DEPTH signed 32-bit
// elements is addressed as a row-major array of 1 to 4 dimensions set by the
// csr_ registers (index 0 dimension count, 1..4 extents, outermost first;
// the csr port is always ready and may be written while the unit is busy
// clearing). A request beat is taken when start is high and busy is low;
// its response appears on rsp_ for exactly one cycle with rsp_valid high and
// cannot be stalled, so the receiver must capture it on that cycle. Each
// request passes through the index steps, one per dimension on the shared
// multiply-add unit building the index by Horner's rule, then the store
// access and the response strobe, before the unit returns to idle, where
// the next beat can be taken. After reset the unit sweeps the store to
// zero one entry per cycle, holding busy high until all STORE_DEPTH (1024)
// entries are clear. A coordinate at or above its extent, or an index
// beyond the store, gives rsp_ok low, rsp_read_value zero, and leaves the
// store untouched; writes always return zero data.
module multidim_array_access_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // request
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_opcode,
   input  logic [maa_pkg::COORD_W-1:0]          req_coord_0,
   input  logic [maa_pkg::COORD_W-1:0]          req_coord_1,
   input  logic [maa_pkg::COORD_W-1:0]          req_coord_2,
   input  logic [maa_pkg::COORD_W-1:0]          req_coord_3,
   input  logic signed [maa_pkg::DATA_W-1:0]    req_value,
   // response
   output logic                                 rsp_valid,
   output logic signed [maa_pkg::DATA_W-1:0]    rsp_read_value,
   output logic                                 rsp_ok,
   // configuration
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [maa_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [maa_pkg::SIZE_W-1:0]           csr_wdata
);
   import maa_pkg::*;

   cmd_type    cmd;
   status_type status;
   coord_type [FIELD_COUNT-1:0] req_coord;

   // Config writes never stall
   assign csr_ready = 1'b1;

   assign req_coord[0] = req_coord_0;
   assign req_coord[1] = req_coord_1;
   assign req_coord[2] = req_coord_2;
   assign req_coord[3] = req_coord_3;

   // Sequencer: clear sweep, index steps, store access, response strobe
   maa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Config registers, index build, element store
   maa_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_opcode     (req_opcode),
      .req_coord      (req_coord),
      .req_value      (req_value),
      .rsp_read_value (rsp_read_value),
      .rsp_ok         (rsp_ok)
   );

   // An accepted beat always makes the unit busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   // Response strobe is a single cycle
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // No new beat can be taken while a response is shown
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response shown while idle");

   // Failed accesses return zero data
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_read_value == '0))
      else $error("nonzero data on failed access");

endmodule

// ----- src/maa_ctrl.sv -----
module maa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  maa_pkg::status_type status,
   output maa_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                rsp_valid
);
   import maa_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_STEP,
      ST_MEM,
      ST_RESP
   } state_type;

   state_type state_ff;
   dsel_type  dim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         dim_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               if (status.clear_last) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_STEP;
                  dim_ff   <= '0;
               end
            end
            ST_STEP: begin
               if (dim_ff == status.last_dim) state_ff <= ST_MEM;
               else dim_ff <= dim_ff + 1'b1;
            end
            ST_MEM:  state_ff <= ST_RESP;
            ST_RESP: state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd          = '0;
      cmd.load     = (state_ff == ST_IDLE) && start;
      cmd.step     = (state_ff == ST_STEP);
      cmd.dim_sel  = dim_ff;
      cmd.mem_go   = (state_ff == ST_MEM);
      cmd.clear_go = (state_ff == ST_CLEAR);
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

endmodule

// ----- src/maa_datapath.sv -----
module maa_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  maa_pkg::cmd_type                     cmd,
   output maa_pkg::status_type                  status,
   input  logic                                 csr_valid,
   input  logic [maa_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [maa_pkg::SIZE_W-1:0]           csr_wdata,
   input  logic                                 req_opcode,
   input  maa_pkg::coord_type [maa_pkg::FIELD_COUNT-1:0] req_coord,
   input  logic signed [maa_pkg::DATA_W-1:0]    req_value,
   output logic signed [maa_pkg::DATA_W-1:0]    rsp_read_value,
   output logic                                 rsp_ok
);
   import maa_pkg::*;

   // Configuration
   logic [DCNT_W-1:0] dim_count_ff;
   size_type          size_ff [FIELD_COUNT];

   // Latched request beat
   logic              op_ff;
   coord_type         coord_ff [FIELD_COUNT];
   logic [DATA_W-1:0] value_ff;

   // Index build
   logic [IDX_W-1:0]  acc_ff, acc_in;
   logic              fail_ff, fail_in;
   coord_type         coord_sel;
   size_type          size_sel;
   logic [PROD_W-1:0] prod;

   // Store and result
   logic [DATA_W-1:0] mem [STORE_DEPTH];
   logic [DATA_W-1:0] rd_ff;
   logic              ok_ff;
   logic [IDX_W-1:0]  clr_ff;
   logic [DCNT_W-1:0] dims;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_count_ff <= DCNT_W'(1);
         for (int i = 0; i < FIELD_COUNT; i++) size_ff[i] <= SIZE_W'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DIM_COUNT: dim_count_ff <= csr_wdata[DCNT_W-1:0];
            CSR_SIZE_0:    size_ff[0]   <= csr_wdata;
            CSR_SIZE_1:    size_ff[1]   <= csr_wdata;
            CSR_SIZE_2:    size_ff[2]   <= csr_wdata;
            CSR_SIZE_3:    size_ff[3]   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Zero count means one dimension, large counts saturate
   always_comb begin
      dims = dim_count_ff;
      if (dims == '0) dims = DCNT_W'(1);
      if (dims > DCNT_W'(DIM_LIM)) dims = DCNT_W'(DIM_LIM);
   end

   assign status.last_dim   = DSEL_W'(dims - 1'b1);
   assign status.clear_last = (clr_ff == IDX_W'(STORE_DEPTH - 1));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_opcode;
         value_ff <= req_value;
         for (int i = 0; i < FIELD_COUNT; i++) coord_ff[i] <= req_coord[i];
      end
   end

   assign coord_sel = coord_ff[cmd.dim_sel];
   assign size_sel  = size_ff[cmd.dim_sel];
   assign prod      = PROD_W'(acc_ff) * PROD_W'(size_sel) + PROD_W'(coord_sel);

   // Once past the store the index only grows, so a sticky fail is exact
   always_comb begin
      acc_in  = acc_ff;
      fail_in = fail_ff;
      if (cmd.load) begin
         acc_in  = '0;
         fail_in = 1'b0;
      end else if (cmd.step) begin
         acc_in  = prod[IDX_W-1:0];
         fail_in = fail_ff
                 || (SIZE_W'(coord_sel) >= size_sel)
                 || (prod >= PROD_W'(STORE_DEPTH));
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      fail_ff <= fail_in;
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clear_go) clr_ff <= clr_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_go) begin
         mem[clr_ff] <= '0;
      end else if (cmd.mem_go && !fail_ff && (op_ff == OP_WRITE)) begin
         mem[acc_ff] <= value_ff;
      end
      if (cmd.mem_go) begin
         rd_ff <= mem[acc_ff];
         ok_ff <= !fail_ff;
      end
   end

   assign rsp_ok         = ok_ff;
   assign rsp_read_value = (ok_ff && (op_ff == OP_READ)) ? signed'(rd_ff) : '0;

endmodule

// ----- bench/multidim_array_access_unit_tb.sv -----
`timescale 1ns / 1ps

module multidim_array_access_unit_tb;
   import maa_pkg::*;

   localparam int HOT_SLOTS = 8;
   localparam int RANDOM_SHAPES = 10;
   localparam int BEATS_PER_SHAPE = 50;
   localparam int COORD_MAX = (1 << COORD_W) - 1;
   // csr indexes past the last extent register; writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_PAST_LIST = CSR_SIZE_3 + 3'd1;

   // One request beat: opcode, one coordinate per dimension, store data
   typedef struct packed {
      logic                             opcode;
      coord_type [FIELD_COUNT-1:0]      coord;
      logic signed [DATA_W-1:0]         value;
   } access_beat_type;

   // One response beat
   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic                     ok;
   } access_result_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_opcode = OP_READ;
   coord_type                 req_coord_0 = '0;
   coord_type                 req_coord_1 = '0;
   coord_type                 req_coord_2 = '0;
   coord_type                 req_coord_3 = '0;
   logic signed [DATA_W-1:0]  req_value = '0;
   logic                      rsp_valid;
   logic signed [DATA_W-1:0]  rsp_read_value;
   logic                      rsp_ok;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = CSR_DIM_COUNT;
   size_type                  csr_wdata = '0;

   multidim_array_access_unit dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_coord_0    (req_coord_0),
      .req_coord_1    (req_coord_1),
      .req_coord_2    (req_coord_2),
      .req_coord_3    (req_coord_3),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_read_value (rsp_read_value),
      .rsp_ok         (rsp_ok),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Shadow of the unit: array shape as last written, and store contents.
   // The store image starts all zero, matching the post-reset sweep.
   // ------------------------------------------------------------------
   logic signed [DATA_W-1:0]  store_image [STORE_DEPTH];
   logic [DCNT_W-1:0]         shape_dims;
   size_type                  shape_size [FIELD_COUNT];

   access_beat_type           pending_access_q [$];
   access_result_type         expected_result_q [$];

   int unsigned               hold_off = 0;
   bit                        steady_run = 1'b0;
   int unsigned               accepted_count = 0;
   int unsigned               checked_count = 0;
   int unsigned               in_bounds_count = 0;
   int unsigned               mismatch_count = 0;
   int unsigned               shape_count = 0;
   access_result_type         want;

   // Hard stop in case the unit hangs or drops a beat
   initial begin
      #5_000_000;
      $display("%0t: timeout, requests left %0d, responses owed %0d",
               $time, pending_access_q.size(), expected_result_q.size());
      $display("status: fail");
      $finish;
   end

   // Dimension count as the unit uses it: zero acts as one, large values clamp
   function automatic int unsigned dims_used();
      int unsigned n;
      n = shape_dims;
      if (n < 1) n = 1;
      if (n > MAX_DIMS) n = MAX_DIMS;
      if (n > FIELD_COUNT) n = FIELD_COUNT;
      return n;
   endfunction

   // Row-major flatten by Horner's rule, bounds check, then the store access.
   // Called once per accepted beat, in accept order, so writes land in order.
   function automatic access_result_type resolve_access(input access_beat_type beat);
      access_result_type res;
      longint unsigned   flat;
      res.read_value = '0;
      res.ok = 1'b1;
      flat = 0;
      for (int d = 0; d < dims_used(); d++) begin
         if (beat.coord[d] >= shape_size[d])
            res.ok = 1'b0;
         else
            flat = flat * shape_size[d] + beat.coord[d];
      end
      // extents above the store size can still walk off the end
      if (flat >= STORE_DEPTH) res.ok = 1'b0;
      if (res.ok) begin
         if (beat.opcode == OP_WRITE)
            store_image[flat[IDX_W-1:0]] = beat.value;
         else
            res.read_value = store_image[flat[IDX_W-1:0]];
      end
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Request driver: presents the head of the pending queue, pops it on
   // accept (start & !busy), then waits a random hold-off before the next.
   // Every so often it flips into a run with no gaps at all.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         hold_off = 0;
      end else begin
         if (start && !busy) begin
            expected_result_q.push_back(resolve_access(pending_access_q.pop_front()));
            accepted_count++;
            if ($urandom_range(0, 24) == 0) steady_run = !steady_run;
            hold_off = steady_run ? 0 : $urandom_range(0, 10);
         end
         // free to change the request only when none is waiting on busy
         if (!start || !busy) begin
            if (hold_off > 0) begin
               hold_off--;
               start <= 1'b0;
            end else if (pending_access_q.size() > 0) begin
               start       <= 1'b1;
               req_opcode  <= pending_access_q[0].opcode;
               req_coord_0 <= pending_access_q[0].coord[0];
               req_coord_1 <= pending_access_q[0].coord[1];
               req_coord_2 <= pending_access_q[0].coord[2];
               req_coord_3 <= pending_access_q[0].coord[3];
               req_value   <= pending_access_q[0].value;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Response monitor: the strobe lasts one cycle and cannot be stalled,
   // so every rsp_valid edge is a beat to compare against the oldest entry.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_result_q.size() == 0) begin
            $display("%0t: unexpected response beat, expected none, got read_value %0d ok %0b",
                     $time, rsp_read_value, rsp_ok);
            mismatch_count++;
         end else begin
            want = expected_result_q.pop_front();
            if (rsp_read_value !== want.read_value) begin
               $display("%0t: read_value mismatch, expected %0d, got %0d",
                        $time, want.read_value, rsp_read_value);
               mismatch_count++;
            end
            if (rsp_ok !== want.ok) begin
               $display("%0t: ok mismatch, expected %0b, got %0b", $time, want.ok, rsp_ok);
               mismatch_count++;
            end
            checked_count++;
            if (want.ok) in_bounds_count++;
         end
      end
   end

   // csr beat: hold valid until ready, then update the shadow shape
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input size_type data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      if (idx == CSR_DIM_COUNT)
         shape_dims = data[DCNT_W-1:0];
      else if (idx <= CSR_SIZE_3)
         shape_size[DSEL_W'(idx - CSR_SIZE_0)] = data;
   endtask

   task automatic set_shape(input int dims, input int s0, input int s1,
                            input int s2, input int s3);
      write_reg(CSR_DIM_COUNT, size_type'(dims));
      write_reg(CSR_SIZE_0, size_type'(s0));
      write_reg(CSR_SIZE_1, size_type'(s1));
      write_reg(CSR_SIZE_2, size_type'(s2));
      write_reg(CSR_SIZE_3, size_type'(s3));
      shape_count++;
   endtask

   // Unit idle: nothing queued, nothing owed, busy low (also covers the
   // store sweep after reset)
   task automatic wait_quiet();
      while (pending_access_q.size() != 0 || expected_result_q.size() != 0 || busy !== 1'b0)
         @(posedge clock);
   endtask

   task automatic queue_access(input logic op, input int c0, input int c1, input int c2,
                               input int c3, input logic [DATA_W-1:0] data);
      access_beat_type beat;
      beat.opcode = op;
      beat.coord[0] = coord_type'(c0);
      beat.coord[1] = coord_type'(c1);
      beat.coord[2] = coord_type'(c2);
      beat.coord[3] = coord_type'(c3);
      beat.value = data;
      pending_access_q.push_back(beat);
   endtask

   // Coordinates mostly inside the current shape; the rest sit on the bound
   // or anywhere in the field. Unused dimensions get full-range noise.
   function automatic access_beat_type fresh_coords();
      access_beat_type beat;
      beat = '0;
      for (int d = 0; d < FIELD_COUNT; d++) begin
         if (d < dims_used() && shape_size[d] != 0 && $urandom_range(0, 7) != 0)
            beat.coord[d] = coord_type'($urandom_range(0,
               (shape_size[d] > COORD_MAX) ? COORD_MAX : shape_size[d] - 1));
         else if (d < dims_used() && shape_size[d] <= COORD_MAX && $urandom_range(0, 1) == 0)
            beat.coord[d] = coord_type'(shape_size[d]);
         else
            beat.coord[d] = coord_type'($urandom_range(0, COORD_MAX));
      end
      return beat;
   endfunction

   // Random shape, then a burst of reads and writes. Half the beats reuse a
   // few hot coordinates so reads come back to data written earlier.
   task automatic random_shape(input int count);
      size_type        dims;
      size_type        sz [FIELD_COUNT];
      int unsigned     used;
      access_beat_type hot [HOT_SLOTS];
      access_beat_type beat;
      dims = ($urandom_range(0, 7) == 0) ? size_type'($urandom_range(0, 7))
                                         : size_type'($urandom_range(1, 4));
      used = (dims < 1) ? 1 : (dims > FIELD_COUNT) ? FIELD_COUNT : dims;
      for (int d = 0; d < FIELD_COUNT; d++) begin
         if (d < used) begin
            case ($urandom_range(0, 31))
               0:       sz[d] = '0;
               1:       sz[d] = size_type'(STORE_DEPTH);
               2:       sz[d] = '1;
               default: sz[d] = size_type'($urandom_range(1,
                                   (used == 1) ? 2047 : (1 << (10 / used + 1))));
            endcase
         end else begin
            sz[d] = size_type'($urandom_range(0, 2047));
         end
      end
      set_shape(dims, sz[0], sz[1], sz[2], sz[3]);
      for (int h = 0; h < HOT_SLOTS; h++) hot[h] = fresh_coords();
      repeat (count) begin
         beat = ($urandom_range(0, 1) == 0) ? hot[$urandom_range(0, HOT_SLOTS - 1)]
                                            : fresh_coords();
         beat.opcode = ($urandom_range(0, 1) == 0) ? OP_READ : OP_WRITE;
         beat.value = $urandom;
         pending_access_q.push_back(beat);
      end
      wait_quiet();
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      for (int i = 0; i < STORE_DEPTH; i++) store_image[i] = '0;
      shape_dims = 3'd1;
      for (int d = 0; d < FIELD_COUNT; d++) shape_size[d] = size_type'(1);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait_quiet();

      // reset shape: one dimension of one element
      queue_access(OP_READ,  0, 0, 0, 0, 32'h0);
      queue_access(OP_WRITE, 0, 0, 0, 0, 32'h8000_0000);
      queue_access(OP_READ,  0, 0, 0, 0, 32'h0);
      queue_access(OP_READ,  1, 0, 0, 0, 32'h0);
      queue_access(OP_WRITE, COORD_MAX, 0, 0, 0, 32'hFFFF_FFFF);
      wait_quiet();

      // four dimensions exactly filling the store; last element and bounds
      set_shape(4, 4, 4, 8, 8);
      queue_access(OP_WRITE, 3, 3, 7, 7, 32'h7FFF_FFFF);
      queue_access(OP_READ,  3, 3, 7, 7, 32'h0);
      queue_access(OP_READ,  0, 0, 0, 8, 32'h0);
      queue_access(OP_READ,  COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 32'h0);
      queue_access(OP_WRITE, 0, 0, 0, 0, 32'hFFFF_FFFF);
      queue_access(OP_READ,  0, 0, 0, 0, 32'h0);
      wait_quiet();

      // zero dimension count acts as one; writes past the register list drop
      set_shape(0, STORE_DEPTH, 0, 0, 0);
      for (int r = CSR_PAST_LIST; r < (1 << CSR_IDX_W); r++)
         write_reg(r[CSR_IDX_W-1:0], '1);
      queue_access(OP_READ,  COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 32'h0);
      queue_access(OP_WRITE, 512, 0, 0, 0, 32'h5555_5555);
      queue_access(OP_READ,  512, 0, 0, 0, 32'h0);
      wait_quiet();

      // oversized dimension count clamps to four
      set_shape(7, STORE_DEPTH, 1, 1, 1);
      queue_access(OP_READ, COORD_MAX, 0, 0, 0, 32'h0);
      queue_access(OP_READ, COORD_MAX, 1, 0, 0, 32'h0);
      queue_access(OP_READ, 512, 0, 0, 1, 32'h0);
      wait_quiet();

      // zero extent: nothing is in bounds
      set_shape(2, 0, STORE_DEPTH, 1, 1);
      queue_access(OP_READ,  0, 0, 0, 0, 32'h0);
      queue_access(OP_WRITE, 0, 5, 0, 0, 32'h1234_5678);
      wait_quiet();

      // extents above range: coordinates pass, and the flat index can run off the store
      set_shape(2, 2047, 2047, 1, 1);
      queue_access(OP_READ,  0, COORD_MAX, 0, 0, 32'h0);
      queue_access(OP_WRITE, 1, 0, 0, 0, 32'hA5A5_A5A5);
      queue_access(OP_WRITE, 0, 1000, 0, 0, 32'h0F0F_0F0F);
      queue_access(OP_READ,  0, 1000, 0, 0, 32'h0);
      wait_quiet();

      repeat (RANDOM_SHAPES) random_shape(BEATS_PER_SHAPE);

      // allow for a stray late beat
      repeat (20) @(posedge clock);
      $display("covered %0d request beats over %0d array shapes, %0d responses checked",
               accepted_count, shape_count, checked_count);
      $display("%0d accesses in bounds, %0d rejected, %0d mismatches",
               in_bounds_count, checked_count - in_bounds_count, mismatch_count);
      if (mismatch_count == 0 && expected_result_q.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ----- sim.f -----
src/maa_pkg.sv
src/maa_ctrl.sv
src/maa_datapath.sv
src/multidim_array_access_unit.sv
bench/multidim_array_access_unit_tb.sv
